// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Types, codes and ring index helpers shared by the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Store geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Fixed field widths of the command and response items
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [COUNT_W-1:0]     count_field_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CNT_W:0]         sum_t;

  typedef enum logic [2:0] {
    OP_NOP        = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    word_t      push_value;
  } cmd_t;

  typedef struct packed {
    word_t        popped_value;
    word_t        front_value;
    word_t        back_value;
    count_field_t entry_count;
    logic         is_empty;
    logic         is_full;
    logic [1:0]   error_code;
  } rsp_t;

  // Advance an index by an offset of at most DEPTH, wrapping once
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    sum_t s;
    s = sum_t'(base) + sum_t'(off);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return idx_t'(s);
  endfunction

  // Step an index back by one, wrapping at zero
  function automatic idx_t ring_dec(idx_t base);
    idx_t r;
    if (base == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = base - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue in a ring RAM with cached front and back values.
// ----------------------------------------------------------------------------
//
//  channel   ports                 handshake
//  --------  --------------------  ------------------------------------------
//  command   cmd (dq_pkg::cmd_t)   item taken at clk edge with start && !busy
//  response  result (dq_pkg::rsp_t) item valid for one cycle while done high
//
// For push, clear, nop, errors and a pop that empties the queue, the response
// follows in the next cycle and busy stays low.
// A pop that leaves entries goes through ST_LOAD: busy is high for one cycle while
// the single RAM read port fetches the new front or back entry into its cache.
// The RAM needs no clearing pass; the block takes items from the first cycle
// after reset. The receiver cannot stall, so done is never held off.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dq_pkg::cmd_t  cmd,
  output logic          done,
  output dq_pkg::rsp_t  result
);

  dq_pkg::state_e state, state_next;

  dq_pkg::idx_t   front_index, front_index_next;
  dq_pkg::cnt_t   occupancy, occupancy_next;
  dq_pkg::value_t front_cache, front_cache_next;
  dq_pkg::value_t back_cache, back_cache_next;
  logic           load_front, load_front_next;
  dq_pkg::rsp_t   rsp, rsp_next;
  logic           done_next;

  logic           accept;
  logic           need_read;
  logic           ram_we;
  dq_pkg::idx_t   ram_waddr;
  dq_pkg::value_t ram_wdata;
  logic           ram_re;
  dq_pkg::idx_t   ram_raddr;
  dq_pkg::value_t ram_rdata;
  dq_pkg::value_t push_val;

  assign accept   = start && (state == dq_pkg::ST_IDLE);
  assign push_val = dq_pkg::value_t'(cmd.push_value);

  // Entry store
  dq_ram #(
    .WIDTH (dq_pkg::VALUE_WIDTH),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dq_pkg::ST_IDLE: begin
        if (accept && need_read) begin
          state_next = dq_pkg::ST_LOAD;
        end
      end
      dq_pkg::ST_LOAD: begin
        state_next = dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      dq_pkg::ST_LOAD: busy = 1'b1;
      default:         busy = 1'b0;
    endcase
  end

  // Decode the item, update index and count, drive the RAM, build the response
  always_comb begin
    front_index_next = front_index;
    occupancy_next   = occupancy;
    front_cache_next = front_cache;
    back_cache_next  = back_cache;
    load_front_next  = load_front;
    rsp_next         = rsp;
    done_next        = 1'b0;
    need_read        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = front_index;
    ram_wdata        = push_val;
    ram_re           = 1'b0;
    ram_raddr        = front_index;

    if (accept) begin
      rsp_next.popped_value = '0;
      rsp_next.error_code   = dq_pkg::ERR_OK;
      case (cmd.opcode)
        dq_pkg::OP_PUSH_FRONT: begin
          if (occupancy >= dq_pkg::cnt_t'(dq_pkg::DEPTH)) begin
            rsp_next.error_code = dq_pkg::ERR_FULL;
          end else begin
            front_index_next = dq_pkg::ring_dec(front_index);
            ram_we           = 1'b1;
            ram_waddr        = front_index_next;
            front_cache_next = push_val;
            if (occupancy == '0) begin
              back_cache_next = push_val;
            end
            occupancy_next = occupancy + dq_pkg::cnt_t'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (occupancy >= dq_pkg::cnt_t'(dq_pkg::DEPTH)) begin
            rsp_next.error_code = dq_pkg::ERR_FULL;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = dq_pkg::ring_add(front_index, occupancy);
            back_cache_next = push_val;
            if (occupancy == '0) begin
              front_cache_next = push_val;
            end
            occupancy_next = occupancy + dq_pkg::cnt_t'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (occupancy == '0) begin
            rsp_next.error_code = dq_pkg::ERR_EMPTY;
          end else begin
            rsp_next.popped_value = dq_pkg::word_t'(front_cache);
            front_index_next      = dq_pkg::ring_add(front_index, dq_pkg::cnt_t'(1));
            occupancy_next        = occupancy - dq_pkg::cnt_t'(1);
            // Refill the front cache from the next entry
            if (occupancy_next != '0) begin
              need_read       = 1'b1;
              ram_re          = 1'b1;
              ram_raddr       = front_index_next;
              load_front_next = 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (occupancy == '0) begin
            rsp_next.error_code = dq_pkg::ERR_EMPTY;
          end else begin
            rsp_next.popped_value = dq_pkg::word_t'(back_cache);
            occupancy_next        = occupancy - dq_pkg::cnt_t'(1);
            // Refill the back cache from the entry before the back
            if (occupancy_next != '0) begin
              need_read       = 1'b1;
              ram_re          = 1'b1;
              ram_raddr       = dq_pkg::ring_add(front_index,
                                                 occupancy - dq_pkg::cnt_t'(2));
              load_front_next = 1'b0;
            end
          end
        end
        dq_pkg::OP_CLEAR: begin
          front_index_next = '0;
          occupancy_next   = '0;
        end
        default: begin
          // nop and unused codes leave everything as it is
        end
      endcase

      rsp_next.entry_count = dq_pkg::count_field_t'(occupancy_next);
      rsp_next.is_empty    = (occupancy_next == '0);
      rsp_next.is_full     = (occupancy_next >= dq_pkg::cnt_t'(dq_pkg::DEPTH));
      if (occupancy_next == '0) begin
        rsp_next.front_value = '0;
        rsp_next.back_value  = '0;
      end else begin
        rsp_next.front_value = dq_pkg::word_t'(front_cache_next);
        rsp_next.back_value  = dq_pkg::word_t'(back_cache_next);
      end
      done_next = !need_read;
    end else if (state == dq_pkg::ST_LOAD) begin
      // Patch the refilled end with the RAM data and release the item
      if (load_front) begin
        front_cache_next     = ram_rdata;
        rsp_next.front_value = dq_pkg::word_t'(ram_rdata);
      end else begin
        back_cache_next     = ram_rdata;
        rsp_next.back_value = dq_pkg::word_t'(ram_rdata);
      end
      done_next = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dq_pkg::ST_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      occupancy   <= occupancy_next;
      done        <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    front_cache <= front_cache_next;
    back_cache  <= back_cache_next;
    load_front  <= load_front_next;
    rsp         <= rsp_next;
  end

  assign result = rsp;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the double-ended queue one command at a time against a shadow deque.
// A short script covers the empty and full edges, every opcode and clear, with
// some responses pinned by hand. Random bursts then drive push-heavy and
// pop-heavy runs so the ring wraps and hits full and empty many times.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // Opcodes outside the defined set behave as nop
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct {
    logic [2:0]  opcode;
    word_t       value;
    int unsigned reps;
    bit          pinned;
    rsp_t        rsp;
  } script_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  rsp_t result;

  // Hand-written response for the item on the command port, when set
  logic pin_valid;
  rsp_t pin_rsp;

  // Shadow copy of the deque
  value_t      shadow_store [DEPTH];
  int unsigned head_slot;
  int unsigned live_count;

  rsp_t        due_rsp [$];
  int unsigned mismatches;

  double_ended_queue_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Apply one command to the shadow deque and return its response
  function automatic rsp_t deque_apply(cmd_t c);
    rsp_t        r;
    int unsigned tail;
    r = '0;
    r.error_code = ERR_OK;
    case (c.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (live_count >= DEPTH) begin
          r.error_code = ERR_FULL;
        end else if (c.opcode == OP_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          shadow_store[head_slot] = value_t'(c.push_value);
          live_count++;
        end else begin
          shadow_store[(head_slot + live_count) % DEPTH] = value_t'(c.push_value);
          live_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (live_count == 0) begin
          r.error_code = ERR_EMPTY;
        end else if (c.opcode == OP_POP_FRONT) begin
          r.popped_value = word_t'(shadow_store[head_slot]);
          head_slot = (head_slot + 1) % DEPTH;
          live_count--;
        end else begin
          tail = (head_slot + live_count + DEPTH - 1) % DEPTH;
          r.popped_value = word_t'(shadow_store[tail]);
          live_count--;
        end
      end
      OP_CLEAR: begin
        head_slot = 0;
        live_count = 0;
      end
      default: begin
      end
    endcase
    // Report the ends of what is left
    if (live_count != 0) begin
      tail = (head_slot + live_count + DEPTH - 1) % DEPTH;
      r.front_value = word_t'(shadow_store[head_slot]);
      r.back_value  = word_t'(shadow_store[tail]);
    end
    r.entry_count = count_field_t'(live_count);
    r.is_empty    = (live_count == 0);
    r.is_full     = (live_count >= DEPTH);
    return r;
  endfunction

  function automatic rsp_t mk_rsp(word_t popped, word_t front, word_t back,
                                  int unsigned count, logic empty, logic full,
                                  err_e err);
    rsp_t r;
    r.popped_value = popped;
    r.front_value  = front;
    r.back_value   = back;
    r.entry_count  = count_field_t'(count);
    r.is_empty     = empty;
    r.is_full      = full;
    r.error_code   = err;
    return r;
  endfunction

  function automatic script_row_t row(logic [2:0] opcode, word_t value,
                                      int unsigned reps, bit pinned, rsp_t rsp);
    script_row_t s;
    s.opcode = opcode;
    s.value  = value;
    s.reps   = reps;
    s.pinned = pinned;
    s.rsp    = rsp;
    return s;
  endfunction

  // Random command; mode 0 leans to pushes, 1 to pops, 2 is balanced
  function automatic cmd_t random_cmd(int unsigned mode);
    cmd_t        c;
    int unsigned roll;
    int unsigned push_pct;
    push_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 48;
    roll = $urandom_range(0, 7);
    c.push_value = (roll == 0) ? '0 : (roll == 1) ? '1 : word_t'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      c.opcode = OP_CLEAR;
    end else if (roll < 8) begin
      case ($urandom_range(0, 2))
        0:       c.opcode = OP_NOP;
        1:       c.opcode = OP_RSVD6;
        default: c.opcode = OP_RSVD7;
      endcase
    end else if (roll < 8 + push_pct) begin
      c.opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      c.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    end
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Hold the item on the port until an edge takes it
  task automatic issue_item(cmd_t c, bit pinned, rsp_t r);
    start     <= 1'b1;
    cmd       <= c;
    pin_valid <= pinned;
    pin_rsp   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and drive junk on the command port for a while
  task automatic idle_for(int unsigned cycles);
    start     <= 1'b0;
    cmd       <= cmd_t'({$urandom, $urandom});
    pin_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Check each response against the oldest expectation, then log new items
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (due_rsp.size() == 0) begin
          $display("%0t: response with none expected, got %h", $time, result);
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          check_field("popped_value", want.popped_value, result.popped_value);
          check_field("front_value", want.front_value, result.front_value);
          check_field("back_value", want.back_value, result.back_value);
          check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(result.is_full));
          check_field("error_code", 32'(want.error_code), 32'(result.error_code));
        end
      end
      if (start && !busy) begin
        want = deque_apply(cmd);
        if (pin_valid) begin
          want = pin_rsp;
        end
        due_rsp.push_back(want);
      end
    end
  end

  initial begin : driver
    script_row_t script [$];
    script_row_t s;
    cmd_t        c;
    int unsigned real_items;
    int unsigned burst_left;
    int unsigned mode;
    int unsigned gap;

    rst        <= 1'b1;
    start      <= 1'b0;
    cmd        <= '0;
    pin_valid  <= 1'b0;
    pin_rsp    <= '0;
    head_slot  = 0;
    live_count = 0;
    mismatches = 0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_store[i] = '0;
    end

    // Empty edge, both extremes of the value, fill to full, every opcode
    script.push_back(row(OP_NOP, '0, 1, 1, mk_rsp('0, '0, '0, 0, 1, 0, ERR_OK)));
    script.push_back(row(OP_POP_FRONT, '1, 1, 1, mk_rsp('0, '0, '0, 0, 1, 0, ERR_EMPTY)));
    script.push_back(row(OP_POP_BACK, '0, 1, 1, mk_rsp('0, '0, '0, 0, 1, 0, ERR_EMPTY)));
    script.push_back(row(OP_PUSH_BACK, '1, 1, 1, mk_rsp('0, '1, '1, 1, 0, 0, ERR_OK)));
    script.push_back(row(OP_PUSH_FRONT, '0, 1, 1, mk_rsp('0, '0, '1, 2, 0, 0, ERR_OK)));
    script.push_back(row(OP_PUSH_BACK, 32'h8000_0000, DEPTH - 2, 0, '0));
    script.push_back(row(OP_PUSH_FRONT, 32'h1234_5678, 1, 1,
                         mk_rsp('0, '0, 32'h8000_0000 + DEPTH - 3, DEPTH, 0, 1, ERR_FULL)));
    script.push_back(row(OP_PUSH_BACK, 32'h5555_AAAA, 1, 1,
                         mk_rsp('0, '0, 32'h8000_0000 + DEPTH - 3, DEPTH, 0, 1, ERR_FULL)));
    script.push_back(row(OP_POP_FRONT, '0, 1, 0, '0));
    script.push_back(row(OP_POP_BACK, '0, 1, 0, '0));
    script.push_back(row(OP_RSVD6, '1, 1, 0, '0));
    script.push_back(row(OP_RSVD7, '0, 1, 0, '0));
    script.push_back(row(OP_CLEAR, '1, 1, 1, mk_rsp('0, '0, '0, 0, 1, 0, ERR_OK)));
    script.push_back(row(OP_POP_FRONT, '0, 1, 1, mk_rsp('0, '0, '0, 0, 1, 0, ERR_EMPTY)));
    script.push_back(row(OP_PUSH_FRONT, 32'hDEAD_BEEF, 1, 1,
                         mk_rsp('0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1, 0, 0, ERR_OK)));
    script.push_back(row(OP_POP_BACK, '0, 1, 1,
                         mk_rsp(32'hDEAD_BEEF, '0, '0, 0, 1, 0, ERR_OK)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the script back to back
    foreach (script[i]) begin
      s = script[i];
      for (int unsigned k = 0; k < s.reps; k++) begin
        c.opcode     = s.opcode;
        c.push_value = s.value + k;
        issue_item(c, s.pinned, s.rsp);
      end
    end

    // Random bursts; the bias mode sticks across bursts to reach full and empty
    real_items = 0;
    burst_left = 0;
    mode       = 2;
    while (real_items < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          idle_for(gap);
        end
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) == 0) begin
          mode = $urandom_range(0, 2);
        end
      end
      c = random_cmd(mode);
      issue_item(c, 1'b0, '0);
      burst_left--;
      if (c.opcode inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK,
                           OP_CLEAR}) begin
        real_items++;
      end
    end

    // Drain the outstanding responses
    start     <= 1'b0;
    pin_valid <= 1'b0;
    @(posedge clk);
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && due_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(1_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
